### rtl/vrrf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrrf_pkg: shared types and constants of the video raster register file
// Holds the action codes, register addresses, timing constants and the
// payload structures of the input and result channels.
// ----------------------------------------------------------------------------
package vrrf_pkg;

  // Action codes of one input beat.
  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_BANK  = 2'd3
  } action_e;

  // Register store geometry.
  localparam int unsigned RegCount = 64;
  localparam int unsigned AddrW    = $clog2(RegCount);

  // Register addresses that have special behavior.
  localparam logic [AddrW-1:0] ADDR_CTRL1      = 6'h11;
  localparam logic [AddrW-1:0] ADDR_RASTER     = 6'h12;
  localparam logic [AddrW-1:0] ADDR_CTRL2      = 6'h16;
  localparam logic [AddrW-1:0] ADDR_MEM_PTR    = 6'h18;
  localparam logic [AddrW-1:0] ADDR_IRQ_LATCH  = 6'h19;
  localparam logic [AddrW-1:0] ADDR_IRQ_ENABLE = 6'h1A;
  localparam logic [AddrW-1:0] ADDR_COLOR_LO   = 6'h20;
  localparam logic [AddrW-1:0] ADDR_COLOR_HI   = 6'h2E;
  localparam logic [AddrW-1:0] ADDR_UNUSED_LO  = 6'h2F;

  // Read masks.
  localparam logic [7:0] MASK_CTRL2   = 8'hC0;
  localparam logic [7:0] MASK_LATCH   = 8'h70;
  localparam logic [7:0] MASK_ENABLE  = 8'hF0;
  localparam logic [7:0] MASK_COLOR   = 8'h0F;
  localparam logic [7:0] READ_UNUSED  = 8'hFF;
  localparam logic [7:0] LATCH_SET    = 8'h81;

  // Raster timing.
  localparam logic [6:0] CYCLES_LAST     = 7'd62;
  localparam logic [6:0] CYCLES_PER_LINE = 7'd63;
  localparam logic [8:0] LINES_PER_FRAME = 9'd312;

  // Payload of one input beat.
  typedef struct packed {
    logic [1:0]       action;
    logic [AddrW-1:0] reg_address;
    logic [7:0]       write_data;
    logic [5:0]       tick_count;
    logic [1:0]       bank_select;
  } in_item_t;

  // Payload of one result beat.
  typedef struct packed {
    logic [7:0]  read_data;
    logic        irq_pulse;
    logic [8:0]  raster_line;
    logic [15:0] screen_base;
    logic [15:0] char_base;
    logic [2:0]  video_mode;
    logic [2:0]  scroll_x;
    logic [2:0]  scroll_y;
  } out_item_t;

endpackage

### rtl/vrrf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrrf_if: valid/ready channels of the video raster register file
// One interface for the input beats and one for the result beats.
// ----------------------------------------------------------------------------
interface vrrf_in_if;
  logic               valid;
  logic               ready;
  vrrf_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vrrf_out_if;
  logic                valid;
  logic                ready;
  vrrf_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/video_raster_register_file.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_raster_register_file: raster register file of a PAL video controller
// Register store, raster line counter fed by a CPU cycle accumulator, and
// the raster compare interrupt. One result beat for every input beat.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake    Payload
//  in_i     sink       valid/ready  action, reg_address, write_data,
//                                   tick_count, bank_select
//  out_o    source     valid/ready  read_data, irq_pulse, raster_line,
//                                   screen_base, char_base, video_mode,
//                                   scroll_x, scroll_y
//
// Every beat is decoded and applied in the cycle it is accepted; its result
// is held in the output register and is shown in the next cycle.
// One beat per cycle is sustained while out_o takes the results; the result
// comes from the output register and the registered read port of the store.
// in_i.ready is high while the output register is empty or being taken, so
// a stall on out_o holds the result and back-pressures in_i.
// After reset all registers, the accumulator, line and bank are zero.
// ----------------------------------------------------------------------------
module video_raster_register_file (
  input  logic       clk_i,
  input  logic       rst_ni,
  vrrf_in_if.sink    in_i,
  vrrf_out_if.source out_o
);

  // Registers with side effects or fixed read taps live in flip-flops.
  logic [7:0] r11_q, r11_d;
  logic [7:0] r12_q, r12_d;
  logic [7:0] r16_q, r16_d;
  logic [7:0] r18_q, r18_d;
  logic [7:0] r19_q, r19_d;
  logic [7:0] r1a_q, r1a_d;
  logic [6:0] acc_q, acc_d;
  logic [8:0] line_q, line_d;
  logic [1:0] bank_q, bank_d;

  // Output register.
  logic                out_valid_q;
  vrrf_pkg::out_item_t res_q, res_d;
  logic                rd_mem_q, rd_mem_d;
  logic [7:0]          rd_or_q, rd_or_d;

  logic                       accept;
  vrrf_pkg::action_e          act;
  logic [vrrf_pkg::AddrW-1:0] addr;
  logic [7:0]                 mem_rdata;
  logic                       mem_we;
  logic                       mem_re;
  logic [7:0]                 acc_sum;
  logic [8:0]                 line_inc;
  logic                       advance;
  logic                       irq;

  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign act      = vrrf_pkg::action_e'(in_i.data.action);
  assign addr     = in_i.data.reg_address;
  assign mem_we   = accept && (act == vrrf_pkg::ACT_WRITE);
  assign mem_re   = accept && (act == vrrf_pkg::ACT_READ);

  // General register store.
  vrrf_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (addr),
    .wdata_i (in_i.data.write_data),
    .re_i    (mem_re),
    .raddr_i (addr),
    .rdata_o (mem_rdata)
  );

  // Cycle accumulator and line advance.
  always_comb begin
    acc_sum  = {1'b0, acc_q} + {2'b00, in_i.data.tick_count};
    advance  = (acc_sum > {1'b0, vrrf_pkg::CYCLES_LAST});
    line_inc = line_q + 9'd1;
    if (line_inc >= vrrf_pkg::LINES_PER_FRAME) begin
      line_inc = 9'd0;
    end
  end

  // Next state of the fixed registers and counters.
  always_comb begin
    r11_d  = r11_q;
    r12_d  = r12_q;
    r16_d  = r16_q;
    r18_d  = r18_q;
    r19_d  = r19_q;
    r1a_d  = r1a_q;
    acc_d  = acc_q;
    line_d = line_q;
    bank_d = bank_q;
    irq    = 1'b0;
    case (act)
      vrrf_pkg::ACT_WRITE: begin
        case (addr)
          vrrf_pkg::ADDR_CTRL1:      r11_d = in_i.data.write_data;
          vrrf_pkg::ADDR_RASTER:     r12_d = in_i.data.write_data;
          vrrf_pkg::ADDR_CTRL2:      r16_d = in_i.data.write_data;
          vrrf_pkg::ADDR_MEM_PTR:    r18_d = in_i.data.write_data;
          vrrf_pkg::ADDR_IRQ_LATCH:  r19_d = 8'h00;
          vrrf_pkg::ADDR_IRQ_ENABLE: r1a_d = in_i.data.write_data;
          default: ;
        endcase
      end
      vrrf_pkg::ACT_TICK: begin
        if (advance) begin
          acc_d  = 7'(acc_sum - {1'b0, vrrf_pkg::CYCLES_PER_LINE});
          line_d = line_inc;
          // Raster compare on entering a new line.
          if (r1a_q[0] && (line_inc == {r11_q[7], r12_q})) begin
            irq   = 1'b1;
            r19_d = vrrf_pkg::LATCH_SET;
          end
        end else begin
          acc_d = acc_sum[6:0];
        end
      end
      vrrf_pkg::ACT_BANK: begin
        bank_d = in_i.data.bank_select;
      end
      default: ;
    endcase
  end

  // Read decode: fixed registers give their value now, store entries
  // arrive from the registered read port and get an OR mask.
  always_comb begin
    rd_mem_d = 1'b0;
    rd_or_d  = 8'h00;
    if (act == vrrf_pkg::ACT_READ) begin
      case (addr)
        vrrf_pkg::ADDR_CTRL1:      rd_or_d = {line_q[8], r11_q[6:0]};
        vrrf_pkg::ADDR_RASTER:     rd_or_d = line_q[7:0];
        vrrf_pkg::ADDR_CTRL2:      rd_or_d = r16_q | vrrf_pkg::MASK_CTRL2;
        vrrf_pkg::ADDR_MEM_PTR:    rd_or_d = r18_q;
        vrrf_pkg::ADDR_IRQ_LATCH:  rd_or_d = r19_q | vrrf_pkg::MASK_LATCH;
        vrrf_pkg::ADDR_IRQ_ENABLE: rd_or_d = r1a_q | vrrf_pkg::MASK_ENABLE;
        default: begin
          if (addr >= vrrf_pkg::ADDR_UNUSED_LO) begin
            rd_or_d = vrrf_pkg::READ_UNUSED;
          end else if (addr >= vrrf_pkg::ADDR_COLOR_LO &&
                       addr <= vrrf_pkg::ADDR_COLOR_HI) begin
            rd_mem_d = 1'b1;
            rd_or_d  = vrrf_pkg::MASK_COLOR;
          end else begin
            rd_mem_d = 1'b1;
          end
        end
      endcase
    end
  end

  // Result fields after this beat.
  always_comb begin
    res_d             = '0;
    res_d.irq_pulse   = irq;
    res_d.raster_line = line_d;
    res_d.screen_base = {bank_d, r18_d[7:4], 10'b0};
    res_d.char_base   = {bank_d, r18_d[3:1], 11'b0};
    res_d.video_mode  = {r11_d[6], r11_d[5], r16_d[4]};
    res_d.scroll_x    = r16_d[2:0];
    res_d.scroll_y    = r11_d[2:0];
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r11_q  <= '0;
      r12_q  <= '0;
      r16_q  <= '0;
      r18_q  <= '0;
      r19_q  <= '0;
      r1a_q  <= '0;
      acc_q  <= '0;
      line_q <= '0;
      bank_q <= '0;
    end else if (accept) begin
      r11_q  <= r11_d;
      r12_q  <= r12_d;
      r16_q  <= r16_d;
      r18_q  <= r18_d;
      r19_q  <= r19_d;
      r1a_q  <= r1a_d;
      acc_q  <= acc_d;
      line_q <= line_d;
      bank_q <= bank_d;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q    <= res_d;
      rd_mem_q <= rd_mem_d;
      rd_or_q  <= rd_or_d;
    end
  end

  // Result beat; store reads merge their mask here.
  always_comb begin
    out_o.data           = res_q;
    out_o.data.read_data = rd_mem_q ? (mem_rdata | rd_or_q) : rd_or_q;
  end
  assign out_o.valid = out_valid_q;

endmodule

### rtl/vrrf_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrrf_store: general register store
// A 64 x 8 memory with one write and one registered read port. Per-entry
// valid bits, cleared at reset, make entries read as zero until written.
// ----------------------------------------------------------------------------
module vrrf_store (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       we_i,
  input  logic [vrrf_pkg::AddrW-1:0] waddr_i,
  input  logic [7:0]                 wdata_i,
  input  logic                       re_i,
  input  logic [vrrf_pkg::AddrW-1:0] raddr_i,
  output logic [7:0]                 rdata_o
);

  logic [7:0]                      mem [vrrf_pkg::RegCount];
  logic [vrrf_pkg::RegCount-1:0]   valid_q;
  logic [7:0]                      rdata_q;

  // Memory write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Valid bits mark entries that hold a written byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  // Registered read port; an unwritten entry reads as zero.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= valid_q[raddr_i] ? mem[raddr_i] : 8'h00;
    end
  end

  assign rdata_o = rdata_q;

endmodule
